// File: sv/jnr_pkg.sv
// Shared types and character constants for the JSON number recognizer.
package jnr_pkg;

  // Character codes the grammar cares about
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EXP_L = 8'h65;
  localparam logic [7:0] CH_EXP_U = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Depth of each of the two small queues
  localparam int unsigned QDEPTH = 2;

  // Character classes produced by the front end
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_PLUS,
    CLS_DOT,
    CLS_EXP,
    CLS_OTHER
  } cls_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PART = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Head of the classified-item queue, front to back
  typedef struct packed {
    logic valid;
    cls_t cls;
  } cls_item_t;

  // One result item
  typedef struct packed {
    status_t status;
    logic    is_negative;
    logic    has_fraction;
    logic    has_exponent;
  } res_t;

endpackage

// File: sv/json_number_recognizer.sv
// Top level of the JSON number recognizer: front end, back end and checks.
//
// Feed one character per item; each character gives exactly one result item:
// status 0 (character belongs to the number), 1 (number complete; this
// character ends it and is not part of it, so resend it as the start of
// whatever follows) or 2 (malformed). With status 1 the flags is_negative,
// has_fraction and has_exponent describe the number; otherwise they are 0.
// The block takes one character every cycle while full is low. The front end
// classifies the character into a two-entry queue, and the back end's state
// machine takes one class per cycle, while there is room, into a two-entry
// result queue, from whose head the output ports are driven. Either side
// may stall without stopping the other until its queue fills.
module json_number_recognizer import jnr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic       is_negative,
  output logic       has_fraction,
  output logic       has_exponent
);

  cls_item_t head;
  logic      cls_pop;
  res_t      res;

  jnr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .full      (full),
    .head      (head),
    .cls_pop   (cls_pop)
  );

  jnr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .cls_pop (cls_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign status       = res.status;
  assign is_negative  = res.is_negative;
  assign has_fraction = res.has_fraction;
  assign has_exponent = res.has_exponent;

`ifndef NO_ASSERTIONS
  // Flags stay low unless the number completed
  a_flags_only_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_DONE) |-> (!is_negative && !has_fraction && !has_exponent))
    else $error("result flags set without a completed number");

  // Never show an undefined status code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_PART || status == ST_DONE || status == ST_BAD))
    else $error("undefined status code on result");

  // Back end only takes a class that is there
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    cls_pop |-> head.valid)
    else $error("class taken from an empty queue");

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule

// File: sv/jnr_front.sv
// Front end: accepts characters, classifies them and queues the classes.
module jnr_front import jnr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] char_code,
  output logic       full,
  output cls_item_t  head,
  input  logic       cls_pop
);

  cls_t       slots [QDEPTH];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  cls_t       cls_in;
  logic       accept;
  logic       take;

  // Classify the incoming character
  always_comb begin
    if (char_code == CH_ZERO) begin
      cls_in = CLS_ZERO;
    end else if (char_code > CH_ZERO && char_code <= CH_NINE) begin
      cls_in = CLS_DIGIT;
    end else if (char_code == CH_MINUS) begin
      cls_in = CLS_MINUS;
    end else if (char_code == CH_PLUS) begin
      cls_in = CLS_PLUS;
    end else if (char_code == CH_DOT) begin
      cls_in = CLS_DOT;
    end else if (char_code == CH_EXP_L || char_code == CH_EXP_U) begin
      cls_in = CLS_EXP;
    end else begin
      cls_in = CLS_OTHER;
    end
  end

  assign full   = (count == 2'(QDEPTH));
  assign accept = push && !full;
  assign take   = cls_pop && (count != 2'd0);

  // Track occupancy
  always_comb begin
    case ({accept, take})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Store the class of an accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= cls_in;
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cls   = slots[rd_ptr];

endmodule

// File: sv/jnr_back.sv
// Back end: grammar state machine and result queue.
module jnr_back import jnr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cls_item_t head,
  output logic      cls_pop,
  output logic      empty,
  input  logic      pop,
  output res_t      res
);

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_MINUS   = 4'd1,
    PH_ZERO    = 4'd2,
    PH_INT     = 4'd3,
    PH_DOT     = 4'd4,
    PH_FRAC    = 4'd5,
    PH_EXP     = 4'd6,
    PH_EXPSIGN = 4'd7,
    PH_EXPDIG  = 4'd8
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       negative_seen;
  logic       negative_seen_next;
  logic       fraction_seen;
  logic       fraction_seen_next;
  status_t    status_c;
  res_t       res_c;
  logic       is_dig;
  logic       step;

  res_t       slots [QDEPTH];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       take;

  assign is_dig  = (head.cls == CLS_ZERO) || (head.cls == CLS_DIGIT);
  assign step    = head.valid && (count != 2'(QDEPTH));
  assign cls_pop = step;
  assign take    = pop && !empty;

  // Work out the next phase and status for the head item
  always_comb begin
    status_c           = ST_PART;
    phase_next         = phase;
    negative_seen_next = negative_seen;
    fraction_seen_next = fraction_seen;
    case (phase)
      PH_MINUS: begin
        if (head.cls == CLS_ZERO) begin
          phase_next = PH_ZERO;
        end else if (head.cls == CLS_DIGIT) begin
          phase_next = PH_INT;
        end else begin
          status_c = ST_BAD;
        end
      end
      PH_ZERO: begin
        if (is_dig) begin
          status_c = ST_BAD;
        end else if (head.cls == CLS_DOT) begin
          phase_next = PH_DOT;
        end else if (head.cls == CLS_EXP) begin
          phase_next = PH_EXP;
        end else begin
          status_c = ST_DONE;
        end
      end
      PH_INT: begin
        if (is_dig) begin
          phase_next = PH_INT;
        end else if (head.cls == CLS_DOT) begin
          phase_next = PH_DOT;
        end else if (head.cls == CLS_EXP) begin
          phase_next = PH_EXP;
        end else begin
          status_c = ST_DONE;
        end
      end
      PH_DOT: begin
        if (is_dig) begin
          phase_next         = PH_FRAC;
          fraction_seen_next = 1'b1;
        end else begin
          status_c = ST_BAD;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          phase_next = PH_FRAC;
        end else if (head.cls == CLS_DOT) begin
          status_c = ST_BAD;
        end else if (head.cls == CLS_EXP) begin
          phase_next = PH_EXP;
        end else begin
          status_c = ST_DONE;
        end
      end
      PH_EXP: begin
        if (head.cls == CLS_PLUS || head.cls == CLS_MINUS) begin
          phase_next = PH_EXPSIGN;
        end else if (is_dig) begin
          phase_next = PH_EXPDIG;
        end else begin
          status_c = ST_BAD;
        end
      end
      PH_EXPSIGN: begin
        if (is_dig) begin
          phase_next = PH_EXPDIG;
        end else begin
          status_c = ST_BAD;
        end
      end
      PH_EXPDIG: begin
        if (is_dig) begin
          phase_next = PH_EXPDIG;
        end else if (head.cls == CLS_DOT || head.cls == CLS_EXP) begin
          status_c = ST_BAD;
        end else begin
          status_c = ST_DONE;
        end
      end
      default: begin
        if (head.cls == CLS_MINUS) begin
          phase_next         = PH_MINUS;
          negative_seen_next = 1'b1;
        end else if (head.cls == CLS_ZERO) begin
          phase_next = PH_ZERO;
        end else if (head.cls == CLS_DIGIT) begin
          phase_next = PH_INT;
        end else begin
          status_c = ST_BAD;
        end
      end
    endcase
  end

  // Build the result; flags only go out with a completed number
  always_comb begin
    res_c.status       = status_c;
    res_c.is_negative  = (status_c == ST_DONE) && negative_seen;
    res_c.has_fraction = (status_c == ST_DONE) && fraction_seen;
    res_c.has_exponent = (status_c == ST_DONE) && (phase == PH_EXPDIG);
  end

  // Hold grammar state; return to start after a done or bad result
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      negative_seen <= 1'b0;
      fraction_seen <= 1'b0;
    end else if (step) begin
      if (status_c == ST_PART) begin
        phase         <= phase_next;
        negative_seen <= negative_seen_next;
        fraction_seen <= fraction_seen_next;
      end else begin
        phase         <= PH_START;
        negative_seen <= 1'b0;
        fraction_seen <= 1'b0;
      end
    end
  end

  // Track result queue occupancy
  always_comb begin
    case ({step, take})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Advance result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (step) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Store each result item
  always_ff @(posedge clk) begin
    if (step) begin
      slots[wr_ptr] <= res_c;
    end
  end

  assign empty = (count == 2'd0);
  assign res   = slots[rd_ptr];

endmodule
